### rtl/core/ffa_pkg.sv
// Shared types and codes for the first-fit block allocator.
// No dependencies; imported by ffa_ram users and the top level.
package ffa_pkg;

    // Command kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    // Smallest payload a split-off remainder must keep
    localparam int MIN_SPLIT_BYTES = 16;

    // Incoming transaction
    typedef struct packed {
        logic        kind;
        logic [15:0] request_bytes;
        logic [9:0]  free_offset;
    } t_ffa_cmd;

    // Outgoing transaction
    typedef struct packed {
        logic [1:0] status;
        logic [9:0] payload_offset;
    } t_ffa_result;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_SCAN,
        S_A_MARK,
        S_A_SPLIT,
        S_F_READ,
        S_F_TEST,
        S_M_SCAN,
        S_REPORT
    } t_ffa_state;

endpackage

### rtl/core/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator with free-block coalescing.
// Depends on ffa_pkg (types, codes) and ffa_ram (granule mark store).
//
// The arena of ARENA_BYTES is split into granules of GRANULE_BYTES (a power of
// two); each granule has a header mark and an in-use mark held in one small
// RAM. A transaction is taken when start is high and busy is low. An allocate
// walks the marks one granule per cycle looking for the first free block that
// fits, then writes its in-use mark and, if the remainder is large enough, a
// new header; the walk stops at the first block that fits. A valid free reads
// the named header, then walks every granule once to clear the mark and merge
// free neighbors. Bad sizes and null, out-of-range or misaligned frees go
// straight to the report state; a free whose offset has no header in front
// of it answers after the header read, with no walk. The result is flagged
// by o_result_valid for exactly one cycle and stays on o_result until the
// next report; the receiver cannot stall it. After reset a clearing pass
// over every granule initializes the marks, with busy held high.
module first_fit_block_allocator_unit #(
    parameter int ARENA_BYTES   = 1024,
    parameter int GRANULE_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  ffa_pkg::t_ffa_cmd    i_cmd,
    output logic                 busy,
    output logic                 o_result_valid,
    output ffa_pkg::t_ffa_result o_result
);
    import ffa_pkg::*;

    localparam int NUM_GRANULES = ARENA_BYTES / GRANULE_BYTES;
    localparam int AW           = (NUM_GRANULES > 1) ? $clog2(NUM_GRANULES) : 1;
    localparam int GW           = $clog2(NUM_GRANULES + 1);
    localparam int DW           = GW + 2;
    localparam int GB_LOG       = $clog2(GRANULE_BYTES);
    localparam int SPLIT_REST   = 1 + (MIN_SPLIT_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;

    t_ffa_state        r_state, n_state;
    logic [GW-1:0]     r_pidx, n_pidx;
    logic [AW-1:0]     r_start, n_start;
    logic              r_blk_used, n_blk_used;
    logic              r_have, n_have;
    logic              r_prev_free, n_prev_free;
    logic [AW-1:0]     r_need, n_need;
    logic [AW-1:0]     r_fgran, n_fgran;
    logic              r_split, n_split;
    logic [1:0]        r_status, n_status;
    logic [9:0]        r_offset, n_offset;
    logic              r_out_valid;
    t_ffa_result       r_out;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [1:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [1:0]        ram_rdata;

    ffa_ram #(
        .WIDTH (2),
        .DEPTH (NUM_GRANULES)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Command decode
    logic [16:0] req_ext;
    logic [16:0] need_full;
    logic        size_bad;
    logic [16:0] off_ext;
    logic        free_ok;
    logic [AW-1:0] free_gran;

    assign req_ext   = {1'b0, i_cmd.request_bytes};
    assign need_full = (req_ext + 17'(GRANULE_BYTES - 1)) >> GB_LOG;
    assign size_bad  = (req_ext == 17'd0) || (req_ext > 17'(ARENA_BYTES - GRANULE_BYTES));
    assign off_ext   = {7'd0, i_cmd.free_offset};
    assign free_ok   = (off_ext != 17'd0) && (off_ext < 17'(ARENA_BYTES))
                     && ((off_ext & 17'(GRANULE_BYTES - 1)) == 17'd0);
    assign free_gran = AW'((off_ext >> GB_LOG) - 17'd1);

    // Scan step: the shared subtract/compare unit
    logic            at_end;
    logic            scan_hdr;
    logic            scan_used;
    logic [DW-1:0]   diff;
    logic            scan_fit;
    logic            is_target;
    logic            this_free;
    logic            do_merge;

    assign at_end    = (r_pidx == GW'(NUM_GRANULES));
    assign scan_hdr  = at_end || ram_rdata[1];
    assign scan_used = ram_rdata[0];
    assign diff      = DW'(r_pidx) - DW'(r_start) - DW'(1) - DW'(r_need);
    assign scan_fit  = r_have && !r_blk_used && !diff[DW-1];
    assign is_target = (r_pidx == GW'(r_fgran));
    assign this_free = !scan_used || is_target;
    assign do_merge  = this_free && r_prev_free && (r_pidx != '0);

    // Payload offset of the block at r_start
    logic [31:0] grant_off;
    assign grant_off = (32'(r_start) + 32'd1) << GB_LOG;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_pidx == GW'(NUM_GRANULES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_cmd.kind == KIND_ALLOC) begin
                        n_state = size_bad ? S_REPORT : S_A_SCAN;
                    end else begin
                        n_state = free_ok ? S_F_READ : S_REPORT;
                    end
                end
            end
            S_A_SCAN: begin
                if (scan_hdr && scan_fit) begin
                    n_state = S_A_MARK;
                end else if (at_end) begin
                    n_state = S_REPORT;
                end
            end
            S_A_MARK:  n_state = r_split ? S_A_SPLIT : S_REPORT;
            S_A_SPLIT: n_state = S_REPORT;
            S_F_READ:  n_state = S_F_TEST;
            S_F_TEST:  n_state = ram_rdata[1] ? S_M_SCAN : S_REPORT;
            S_M_SCAN: begin
                if (at_end) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM controls
    always_comb begin
        n_pidx      = r_pidx;
        n_start     = r_start;
        n_blk_used  = r_blk_used;
        n_have      = r_have;
        n_prev_free = r_prev_free;
        n_need      = r_need;
        n_fgran     = r_fgran;
        n_split     = r_split;
        n_status    = r_status;
        n_offset    = r_offset;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_pidx);
        ram_wdata   = 2'b00;
        ram_raddr   = '0;
        case (r_state)
            // Clearing pass: header only at granule zero
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {(r_pidx == '0), 1'b0};
                n_pidx    = r_pidx + GW'(1);
            end
            // Latch the transaction; read address 0 primes the scan
            S_IDLE: begin
                n_pidx      = '0;
                n_have      = 1'b0;
                n_prev_free = 1'b0;
                n_offset    = '0;
                n_need      = AW'(need_full);
                n_fgran     = free_gran;
                if (i_cmd.kind == KIND_ALLOC) begin
                    n_status = size_bad ? ST_BAD_SIZE : ST_NO_FIT;
                end else begin
                    n_status = free_ok ? ST_OK : ST_IGNORED;
                end
            end
            // First-fit walk, one granule per cycle
            S_A_SCAN: begin
                ram_raddr = AW'(r_pidx + GW'(1));
                if (scan_hdr && scan_fit) begin
                    n_status = ST_OK;
                    n_split  = (diff >= DW'(SPLIT_REST));
                end else begin
                    n_pidx = r_pidx + GW'(1);
                    if (scan_hdr) begin
                        n_start    = AW'(r_pidx);
                        n_blk_used = scan_used;
                        n_have     = 1'b1;
                    end
                end
            end
            // Mark the chosen block in use
            S_A_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_start;
                ram_wdata = 2'b11;
                n_offset  = grant_off[9:0];
            end
            // New free header after the granted payload
            S_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_start + AW'(1) + r_need;
                ram_wdata = 2'b10;
            end
            // Look up the header in front of the freed payload
            S_F_READ: begin
                ram_raddr = r_fgran;
            end
            S_F_TEST: begin
                n_pidx      = '0;
                n_prev_free = 1'b0;
                if (!ram_rdata[1]) begin
                    n_status = ST_IGNORED;
                end
            end
            // Release walk: clear the target mark, drop headers of free neighbors
            S_M_SCAN: begin
                ram_raddr = AW'(r_pidx + GW'(1));
                n_pidx    = r_pidx + GW'(1);
                if (!at_end && ram_rdata[1]) begin
                    if (do_merge) begin
                        ram_we    = 1'b1;
                        ram_wdata = 2'b00;
                    end else begin
                        n_prev_free = this_free;
                        if (is_target) begin
                            ram_we    = 1'b1;
                            ram_wdata = 2'b10;
                        end
                    end
                end
                if (at_end) begin
                    n_pidx = r_pidx;
                end
            end
            S_REPORT: begin
                n_pidx = '0;
            end
            default: begin
                n_pidx = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pidx      <= n_pidx;
            r_out_valid <= (r_state == S_REPORT);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_blk_used  <= n_blk_used;
        r_have      <= n_have;
        r_prev_free <= n_prev_free;
        r_need      <= n_need;
        r_fgran     <= n_fgran;
        r_split     <= n_split;
        r_status    <= n_status;
        r_offset    <= n_offset;
        if (r_state == S_REPORT) begin
            r_out.status         <= r_status;
            r_out.payload_offset <= (r_status == ST_OK) ? r_offset : 10'd0;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

### rtl/core/ffa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
